// ===== hw/rtl/pods_pkg.sv =====
`default_nettype none
package pods_pkg;
    localparam int unsigned WINDOW_DEF    = 1024;
    localparam int unsigned REQ_SLOTS_DEF = 16;
    localparam int unsigned SEQ_W         = 16;
    localparam int unsigned TIME_W        = 63;
    localparam int unsigned VAL_W         = 64;

    typedef enum logic [1:0] {
        ACT_REQ  = 2'd0,
        ACT_SYNC = 2'd1,
        ACT_RESP = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_RECORDED  = 3'd0,
        ST_MEASURED  = 3'd1,
        ST_NO_MASTER = 3'd2,
        ST_NO_MATCH  = 3'd3,
        ST_FULL      = 3'd4,
        ST_SYNC_IGN  = 3'd5
    } t_status;
endpackage
`default_nettype wire

// ===== hw/rtl/pods_ram.sv =====
`default_nettype none
module pods_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/ptp_offset_delay_stats.sv =====
// channel   | signals                                      | transfer
// ----------+----------------------------------------------+--------------------------
// command   | i_start, i_action, i_sequence_req, i_time_*  | i_start high, o_busy low
// result    | o_valid, o_status, o_offset_*, o_delay_*,    | o_valid high, one cycle
//           | o_samples_held                               |
// a sync, an unused code or a response before any sync goes from idle straight to
// the done state; a request or response searches the pending table ram slot by
// slot, a read state and a check state per slot, until a hit or the last slot;
// a measurement then steps through the states AB, OFF, DEL, WIN, ADD, DINIT and
// the bit-serial mean divider DIV
// synchronous active-low reset clears control, sums, extremes and valid bits;
// the window ram needs no clearing as the fill count guards it
// results cannot be stalled: o_busy stays high up to and including the strobe cycle
`default_nettype none
module ptp_offset_delay_stats #(
    parameter int unsigned WINDOW    = pods_pkg::WINDOW_DEF,
    parameter int unsigned REQ_SLOTS = pods_pkg::REQ_SLOTS_DEF,
    localparam int unsigned CNT_W = $clog2(WINDOW + 1)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    output logic                          o_busy,
    input  wire logic [1:0]               i_action,
    input  wire logic [15:0]              i_sequence_req,
    input  wire logic [62:0]              i_time_local,
    input  wire logic [62:0]              i_time_remote,
    output logic                          o_valid,
    output logic [2:0]                    o_status,
    output logic signed [63:0]            o_offset_now,
    output logic signed [63:0]            o_offset_mean,
    output logic signed [63:0]            o_offset_min,
    output logic signed [63:0]            o_offset_max,
    output logic signed [63:0]            o_delay_now,
    output logic signed [63:0]            o_delay_mean,
    output logic signed [63:0]            o_delay_min,
    output logic signed [63:0]            o_delay_max,
    output logic [CNT_W-1:0]              o_samples_held
);
    localparam int unsigned SLOT_W = (REQ_SLOTS > 1) ? $clog2(REQ_SLOTS) : 1;
    localparam int unsigned PTR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned VW     = pods_pkg::VAL_W;
    localparam int unsigned SW     = pods_pkg::SEQ_W;
    localparam int unsigned TW     = pods_pkg::TIME_W;
    localparam int unsigned SUM_W  = VW + $clog2(WINDOW + 1) + 1;
    localparam int unsigned STEP_W = $clog2(SUM_W + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_RD     = 11'b00000000010,
        S_CK     = 11'b00000000100,
        S_AB     = 11'b00000001000,
        S_OFF    = 11'b00000010000,
        S_DEL    = 11'b00000100000,
        S_WIN    = 11'b00001000000,
        S_ADD    = 11'b00010000000,
        S_DINIT  = 11'b00100000000,
        S_DIV    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // latched command
    logic [1:0]        r_act;
    logic [SW-1:0]     r_seq;
    logic [TW-1:0]     r_tl, r_tr;

    // sync and pending state
    logic              r_master;
    logic [TW-1:0]     r_origin, r_receive;
    logic [REQ_SLOTS-1:0] r_pvalid;
    logic [SLOT_W-1:0] r_idx;
    logic [TW-1:0]     r_tsend;

    // measurement pipeline
    logic signed [VW-1:0] r_a, r_b, r_off, r_del;

    // statistics
    logic signed [SUM_W-1:0] r_osum, r_dsum;
    logic [CNT_W-1:0]  r_cnt;
    logic [PTR_W-1:0]  r_ptr;
    logic signed [VW-1:0] r_onow, r_omin, r_omax, r_dnow, r_dmin, r_dmax;
    logic              r_ext_vld;
    logic signed [VW-1:0] r_omean, r_dmean;

    // mean dividers
    logic [SUM_W-1:0]  r_odv, r_ddv;
    logic [CNT_W-1:0]  r_orem, r_drem;
    logic              r_oneg, r_dneg;
    logic [STEP_W-1:0] r_step;

    logic [2:0]        r_status;

    // pending table ram
    logic              p_we;
    logic [SLOT_W-1:0] p_waddr;
    logic [SW+TW-1:0]  p_rdata;

    // window ram: {offset, delay}
    logic              w_we;
    logic [2*VW-1:0]   w_rdata;

    pods_ram #(.WIDTH(SW + TW), .DEPTH(REQ_SLOTS)) u_pend (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata ({r_seq, r_tl}),
        .i_raddr (r_idx),
        .o_rdata (p_rdata)
    );

    pods_ram #(.WIDTH(2 * VW), .DEPTH(WINDOW)) u_win (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ptr),
        .i_wdata ({r_off, r_del}),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    // first free slot, lowest index wins
    logic              free_any;
    logic [SLOT_W-1:0] free_idx;
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = REQ_SLOTS - 1; i >= 0; i--) begin
            if (!r_pvalid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    logic hit, last_slot, full;
    assign hit       = r_pvalid[r_idx] && (p_rdata[SW+TW-1:TW] == r_seq);
    assign last_slot = (r_idx == SLOT_W'(REQ_SLOTS - 1));
    assign full      = (r_cnt == CNT_W'(WINDOW));

    assign p_we    = (r_state == S_CK) && !hit && last_slot
                     && (r_act == pods_pkg::ACT_REQ) && free_any;
    assign p_waddr = free_idx;
    assign w_we    = (r_state == S_WIN);

    // offset = trunc((a+b)/2)
    logic signed [VW:0] s65, t65;
    assign s65 = {r_a[VW-1], r_a} + {r_b[VW-1], r_b};
    assign t65 = s65 + {{VW{1'b0}}, s65[VW]};

    // delay = a - offset, saturated
    logic signed [VW:0] d65;
    logic signed [VW-1:0] del_sat;
    assign d65 = {r_a[VW-1], r_a} - {r_off[VW-1], r_off};
    always_comb begin
        if (d65[VW] != d65[VW-1]) begin
            del_sat = d65[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
        end else begin
            del_sat = d65[VW-1:0];
        end
    end

    // one restoring division step
    logic [CNT_W:0] o_sh, d_sh;
    logic           o_ge, d_ge;
    assign o_sh = {r_orem, r_odv[SUM_W-1]};
    assign d_sh = {r_drem, r_ddv[SUM_W-1]};
    assign o_ge = (o_sh >= {1'b0, r_cnt});
    assign d_ge = (d_sh >= {1'b0, r_cnt});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    priority case (i_action)
                        pods_pkg::ACT_REQ:  n_state = S_RD;
                        pods_pkg::ACT_RESP: n_state = r_master ? S_RD : S_DONE;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_RD:  n_state = S_CK;
            S_CK: begin
                if (hit) begin
                    n_state = (r_act == pods_pkg::ACT_RESP) ? S_AB : S_DONE;
                end else if (last_slot) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_AB:    n_state = S_OFF;
            S_OFF:   n_state = S_DEL;
            S_DEL:   n_state = S_WIN;
            S_WIN:   n_state = S_ADD;
            S_ADD:   n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   n_state = (r_step == STEP_W'(SUM_W - 1)) ? S_DONE : S_DIV;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_master  <= 1'b0;
            r_origin  <= '0;
            r_receive <= '0;
            r_pvalid  <= '0;
            r_osum    <= '0;
            r_dsum    <= '0;
            r_cnt     <= '0;
            r_ptr     <= '0;
            r_onow    <= '0;
            r_omin    <= '0;
            r_omax    <= '0;
            r_dnow    <= '0;
            r_dmin    <= '0;
            r_dmax    <= '0;
            r_ext_vld <= 1'b0;
            r_omean   <= '0;
            r_dmean   <= '0;
            r_status  <= pods_pkg::ST_NO_MATCH;
            r_idx     <= '0;
            r_step    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_act    <= i_action;
                        r_seq    <= i_sequence_req;
                        r_tl     <= i_time_local;
                        r_tr     <= i_time_remote;
                        r_idx    <= '0;
                        r_status <= pods_pkg::ST_NO_MATCH;
                        priority case (i_action)
                            pods_pkg::ACT_SYNC: begin
                                r_master <= 1'b1;
                                if (i_time_remote != '0) begin
                                    r_origin  <= i_time_remote;
                                    r_receive <= i_time_local;
                                    r_status  <= pods_pkg::ST_RECORDED;
                                end else begin
                                    r_status <= pods_pkg::ST_SYNC_IGN;
                                end
                            end
                            pods_pkg::ACT_RESP: begin
                                if (!r_master) begin
                                    r_status <= pods_pkg::ST_NO_MASTER;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_CK: begin
                    if (hit) begin
                        r_tsend <= p_rdata[TW-1:0];
                        if (r_act == pods_pkg::ACT_RESP) begin
                            r_pvalid[r_idx] <= 1'b0;
                            r_status <= pods_pkg::ST_MEASURED;
                        end else begin
                            r_status <= pods_pkg::ST_RECORDED;
                        end
                    end else if (last_slot) begin
                        if (r_act == pods_pkg::ACT_REQ) begin
                            if (free_any) begin
                                r_pvalid[free_idx] <= 1'b1;
                                r_status <= pods_pkg::ST_RECORDED;
                            end else begin
                                r_status <= pods_pkg::ST_FULL;
                            end
                        end
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_AB: begin
                    r_a <= $signed({1'b0, r_receive}) - $signed({1'b0, r_origin});
                    r_b <= $signed({1'b0, r_tsend}) - $signed({1'b0, r_tr});
                end
                S_OFF: r_off <= t65[VW:1];
                S_DEL: r_del <= del_sat;
                S_WIN: begin
                    // retire the oldest sample once the window is full
                    if (full) begin
                        r_osum <= r_osum - {{(SUM_W-VW){w_rdata[2*VW-1]}}, w_rdata[2*VW-1:VW]};
                        r_dsum <= r_dsum - {{(SUM_W-VW){w_rdata[VW-1]}}, w_rdata[VW-1:0]};
                    end
                    r_onow <= r_off;
                    r_dnow <= r_del;
                    if (!r_ext_vld || r_off < r_omin) r_omin <= r_off;
                    if (!r_ext_vld || r_off > r_omax) r_omax <= r_off;
                    if (!r_ext_vld || r_del < r_dmin) r_dmin <= r_del;
                    if (!r_ext_vld || r_del > r_dmax) r_dmax <= r_del;
                    r_ext_vld <= 1'b1;
                end
                S_ADD: begin
                    r_osum <= r_osum + {{(SUM_W-VW){r_off[VW-1]}}, r_off};
                    r_dsum <= r_dsum + {{(SUM_W-VW){r_del[VW-1]}}, r_del};
                    if (!full) r_cnt <= r_cnt + 1'b1;
                    r_ptr <= (r_ptr == PTR_W'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                end
                S_DINIT: begin
                    r_oneg <= r_osum[SUM_W-1];
                    r_dneg <= r_dsum[SUM_W-1];
                    r_odv  <= r_osum[SUM_W-1] ? SUM_W'(-r_osum) : r_osum;
                    r_ddv  <= r_dsum[SUM_W-1] ? SUM_W'(-r_dsum) : r_dsum;
                    r_orem <= '0;
                    r_drem <= '0;
                    r_step <= '0;
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    r_odv  <= {r_odv[SUM_W-2:0], o_ge};
                    r_ddv  <= {r_ddv[SUM_W-2:0], d_ge};
                    r_orem <= o_ge ? CNT_W'(o_sh - {1'b0, r_cnt}) : o_sh[CNT_W-1:0];
                    r_drem <= d_ge ? CNT_W'(d_sh - {1'b0, r_cnt}) : d_sh[CNT_W-1:0];
                    if (r_step == STEP_W'(SUM_W - 1)) begin
                        r_omean <= r_oneg ? -$signed({r_odv[VW-2:0], o_ge})
                                          : $signed({r_odv[VW-2:0], o_ge});
                        r_dmean <= r_dneg ? -$signed({r_ddv[VW-2:0], d_ge})
                                          : $signed({r_ddv[VW-2:0], d_ge});
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_DONE);
    assign o_status       = r_status;
    assign o_offset_now   = r_onow;
    assign o_offset_mean  = r_omean;
    assign o_offset_min   = r_omin;
    assign o_offset_max   = r_omax;
    assign o_delay_now    = r_dnow;
    assign o_delay_mean   = r_dmean;
    assign o_delay_min    = r_dmin;
    assign o_delay_max    = r_dmax;
    assign o_samples_held = r_cnt;
endmodule
`default_nettype wire

// ===== dv/ptp_offset_delay_stats_tb.sv =====
`timescale 1ns / 1ps
module ptp_offset_delay_stats_tb;
    localparam int unsigned WIN    = pods_pkg::WINDOW_DEF;
    localparam int unsigned SLOTS  = pods_pkg::REQ_SLOTS_DEF;
    localparam int unsigned CNT_W  = $clog2(WIN + 1);
    localparam longint      LIMIT  = 4_000_000;
    localparam logic [62:0] T_MAX  = {63{1'b1}};
    localparam int unsigned EXP_D  = 8;

    typedef struct {
        pods_pkg::t_status status;
        logic [63:0]    off_now, off_mean, off_min, off_max;
        logic [63:0]    del_now, del_mean, del_min, del_max;
        logic [CNT_W-1:0] held;
    } t_ptp_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic [1:0]        i_action = pods_pkg::ACT_NONE;
    logic [15:0]       i_sequence_req = '0;
    logic [62:0]       i_time_local = '0;
    logic [62:0]       i_time_remote = '0;
    wire               o_busy;
    wire               o_valid;
    wire [2:0]         o_status;
    wire signed [63:0] o_offset_now, o_offset_mean, o_offset_min, o_offset_max;
    wire signed [63:0] o_delay_now, o_delay_mean, o_delay_min, o_delay_max;
    wire [CNT_W-1:0]   o_samples_held;

    ptp_offset_delay_stats uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_action(i_action), .i_sequence_req(i_sequence_req),
        .i_time_local(i_time_local), .i_time_remote(i_time_remote),
        .o_valid(o_valid), .o_status(o_status),
        .o_offset_now(o_offset_now), .o_offset_mean(o_offset_mean),
        .o_offset_min(o_offset_min), .o_offset_max(o_offset_max),
        .o_delay_now(o_delay_now), .o_delay_mean(o_delay_mean),
        .o_delay_min(o_delay_min), .o_delay_max(o_delay_max),
        .o_samples_held(o_samples_held)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state, mirrors the block's architectural state
    logic               master_seen;
    logic [62:0]        sync_org, sync_rx;
    logic               pend_vld [SLOTS];
    logic [15:0]        pend_seq [SLOTS];
    logic [62:0]        pend_t   [SLOTS];
    logic [63:0]        off_win  [WIN];
    logic [63:0]        del_win  [WIN];
    logic signed [127:0] off_sum, del_sum;
    int unsigned        win_cnt, win_ptr;
    logic [63:0]        off_last, off_lo, off_hi, del_last, del_lo, del_hi;
    logic               ext_vld;

    // expected results in order
    t_ptp_result exp_fifo [EXP_D];
    int unsigned exp_wr = 0, exp_rd = 0;
    int          mismatches = 0;
    int          n_measured = 0, n_full = 0, n_results = 0;
    longint      cycles = 0;
    logic        finished = 1'b0;
    logic        start_low = 1'b1;

    function automatic logic [63:0] window_mean(logic signed [127:0] sum);
        logic signed [127:0] cnt;
        logic signed [127:0] q;
        if (win_cnt == 0) return '0;
        cnt = win_cnt;
        q = sum / cnt;  // truncates toward zero
        return q[63:0];
    endfunction

    function automatic int find_slot(logic [15:0] seq);
        for (int i = 0; i < SLOTS; i++)
            if (pend_vld[i] && pend_seq[i] == seq) return i;
        return -1;
    endfunction

    function automatic int pending_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++) if (pend_vld[i]) n++;
        return n;
    endfunction

    function automatic void reset_predictor();
        master_seen = 1'b0;
        sync_org = '0;
        sync_rx = '0;
        for (int i = 0; i < SLOTS; i++) pend_vld[i] = 1'b0;
        off_sum = '0;
        del_sum = '0;
        win_cnt = 0;
        win_ptr = 0;
        off_last = '0;
        off_lo = '0;
        off_hi = '0;
        del_last = '0;
        del_lo = '0;
        del_hi = '0;
        ext_vld = 1'b0;
    endfunction

    // one offset/delay sample from a matched response
    function automatic void take_sample(logic [62:0] t_send, logic [62:0] t_rem);
        logic signed [65:0] a, b, off, del;
        logic [63:0] o64, d64;
        logic full;
        a = $signed({3'b0, sync_rx}) - $signed({3'b0, sync_org});
        b = $signed({3'b0, t_send}) - $signed({3'b0, t_rem});
        off = (a + b) / 66'sd2;
        del = a - off;
        // delay saturates at the signed 64-bit limits
        if (del > $signed({2'b00, 1'b0, {63{1'b1}}})) del = {2'b00, 1'b0, {63{1'b1}}};
        if (del < $signed({2'b11, 1'b1, 63'd0})) del = {2'b11, 1'b1, 63'd0};
        o64 = off[63:0];
        d64 = del[63:0];
        full = (win_cnt >= WIN);
        if (full) begin
            off_sum -= $signed(off_win[win_ptr]);
            del_sum -= $signed(del_win[win_ptr]);
        end
        off_win[win_ptr] = o64;
        del_win[win_ptr] = d64;
        off_sum += $signed(o64);
        del_sum += $signed(d64);
        off_last = o64;
        del_last = d64;
        if (!ext_vld) begin
            // first sample sets both extremes
            {off_lo, off_hi, del_lo, del_hi} = {o64, o64, d64, d64};
        end else begin
            if ($signed(o64) < $signed(off_lo)) off_lo = o64;
            if ($signed(o64) > $signed(off_hi)) off_hi = o64;
            if ($signed(d64) < $signed(del_lo)) del_lo = d64;
            if ($signed(d64) > $signed(del_hi)) del_hi = d64;
        end
        ext_vld = 1'b1;
        if (!full) win_cnt++;
        win_ptr = (win_ptr + 1) % WIN;
    endfunction

    function automatic void predict_ptp(logic [1:0] act, logic [15:0] seq,
                                        logic [62:0] tl, logic [62:0] tr);
        t_ptp_result r;
        int slot;
        r.status = pods_pkg::ST_NO_MATCH;
        case (act)
            pods_pkg::ACT_REQ: begin
                if (find_slot(seq) >= 0) begin
                    r.status = pods_pkg::ST_RECORDED;  // duplicate sequence
                end else begin
                    r.status = pods_pkg::ST_FULL;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (!pend_vld[i]) begin
                            pend_vld[i] = 1'b1;
                            pend_seq[i] = seq;
                            pend_t[i] = tl;
                            r.status = pods_pkg::ST_RECORDED;
                            break;
                        end
                    end
                end
            end
            pods_pkg::ACT_SYNC: begin
                master_seen = 1'b1;
                if (tr != 0) begin
                    sync_org = tr;
                    sync_rx = tl;
                    r.status = pods_pkg::ST_RECORDED;
                end else begin
                    r.status = pods_pkg::ST_SYNC_IGN;
                end
            end
            pods_pkg::ACT_RESP: begin
                if (!master_seen) begin
                    r.status = pods_pkg::ST_NO_MASTER;
                end else begin
                    slot = find_slot(seq);
                    if (slot >= 0) begin
                        take_sample(pend_t[slot], tr);
                        pend_vld[slot] = 1'b0;
                        r.status = pods_pkg::ST_MEASURED;
                    end
                end
            end
            default: ;
        endcase
        if (r.status == pods_pkg::ST_MEASURED) n_measured++;
        if (r.status == pods_pkg::ST_FULL) n_full++;
        r.off_now = off_last;
        r.off_mean = window_mean(off_sum);
        r.off_min = off_lo;
        r.off_max = off_hi;
        r.del_now = del_last;
        r.del_mean = window_mean(del_sum);
        r.del_min = del_lo;
        r.del_max = del_hi;
        r.held = win_cnt[CNT_W-1:0];
        exp_fifo[exp_wr[2:0]] = r;
        exp_wr++;
    endfunction

    // mostly back to back, sometimes a short pause, rarely a long one
    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        n = (r < 55) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (n > 0) begin
            i_start <= 1'b0;
            start_low = 1'b1;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // one command transfer; start is left high so the next one can follow at once
    task automatic send_cmd(logic [1:0] act, logic [15:0] seq,
                            logic [62:0] tl, logic [62:0] tr);
        i_start <= 1'b1;
        start_low = 1'b0;
        i_action <= act;
        i_sequence_req <= seq;
        i_time_local <= tl;
        i_time_remote <= tr;
        do @(posedge i_clk); while (o_busy);
        predict_ptp(act, seq, tl, tr);
        idle_gap();
    endtask

    task automatic drain();
        if (!start_low) begin
            i_start <= 1'b0;
            start_low = 1'b1;
        end
        @(posedge i_clk);
        wait (exp_wr == exp_rd);
        @(posedge i_clk);
    endtask

    function automatic logic [62:0] rand_time();
        return 63'({$urandom, $urandom});
    endfunction

    // result checker: results cannot be held off, so every strobe is compared
    always @(posedge i_clk) begin
        t_ptp_result e;
        cycles <= cycles + 1;
        if (i_rst_n && o_valid) begin
            n_results++;
            if (exp_wr == exp_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing expected, status %0d", o_status);
            end else begin
                e = exp_fifo[exp_rd[2:0]];
                exp_rd++;
                if (o_status !== e.status || o_offset_now !== e.off_now ||
                    o_offset_mean !== e.off_mean || o_offset_min !== e.off_min ||
                    o_offset_max !== e.off_max || o_delay_now !== e.del_now ||
                    o_delay_mean !== e.del_mean || o_delay_min !== e.del_min ||
                    o_delay_max !== e.del_max || o_samples_held !== e.held) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result %0d mismatch", n_results);
                        $display("  status   exp %0d got %0d", e.status, o_status);
                        $display("  off now/mean/min/max exp %0d %0d %0d %0d",
                                 $signed(e.off_now), $signed(e.off_mean),
                                 $signed(e.off_min), $signed(e.off_max));
                        $display("                       got %0d %0d %0d %0d",
                                 o_offset_now, o_offset_mean, o_offset_min, o_offset_max);
                        $display("  del now/mean/min/max exp %0d %0d %0d %0d",
                                 $signed(e.del_now), $signed(e.del_mean),
                                 $signed(e.del_min), $signed(e.del_max));
                        $display("                       got %0d %0d %0d %0d",
                                 o_delay_now, o_delay_mean, o_delay_min, o_delay_max);
                        $display("  held     exp %0d got %0d", e.held, o_samples_held);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!finished && cycles > LIMIT) begin
            $display("ERROR: timeout with %0d results outstanding", exp_wr - exp_rd);
            $display("Test completed with failures");
            $finish;
        end
    end

    // requests, responses and unused codes before any sync has been seen
    task automatic test_no_master();
        send_cmd(pods_pkg::ACT_RESP, 16'h0000, '0, '0);
        send_cmd(pods_pkg::ACT_REQ, 16'h0001, 63'd1000, '0);
        send_cmd(pods_pkg::ACT_RESP, 16'h0001, T_MAX, T_MAX);  // still no master
        send_cmd(pods_pkg::ACT_NONE, 16'hffff, T_MAX, T_MAX);
    endtask

    // zero origin sync marks the master but keeps the old times
    task automatic test_sync();
        send_cmd(pods_pkg::ACT_SYNC, 16'h0000, T_MAX, '0);
        send_cmd(pods_pkg::ACT_RESP, 16'h0001, '0, 63'd0);  // measures with zero sync times
        send_cmd(pods_pkg::ACT_SYNC, 16'hffff, T_MAX, 63'd1);
    endtask

    // duplicates, misses and extreme timestamps
    task automatic test_requests();
        send_cmd(pods_pkg::ACT_REQ, 16'hffff, '0, '0);
        send_cmd(pods_pkg::ACT_REQ, 16'hffff, T_MAX, '0);     // duplicate, first time kept
        send_cmd(pods_pkg::ACT_RESP, 16'h1234, '0, '0);       // no pending request
        send_cmd(pods_pkg::ACT_RESP, 16'hffff, '0, T_MAX);    // zero offset, large delay
        send_cmd(pods_pkg::ACT_SYNC, 16'h0000, 63'd1, T_MAX);
        send_cmd(pods_pkg::ACT_REQ, 16'h8000, T_MAX, '0);
        send_cmd(pods_pkg::ACT_RESP, 16'h8000, '0, '0);
        send_cmd(pods_pkg::ACT_SYNC, 16'h0000, T_MAX, 63'd1); // large delay near the signed limit
        send_cmd(pods_pkg::ACT_REQ, 16'h0002, 63'd0, '0);
        send_cmd(pods_pkg::ACT_RESP, 16'h0002, '0, T_MAX);
        send_cmd(pods_pkg::ACT_NONE, 16'h5555, 63'h2aaa_aaaa_aaaa_aaaa,
                 63'h5555_5555_5555_5555);
    endtask

    // fill the request table, overflow it, then empty it
    task automatic test_table_full();
        for (int i = 0; i < SLOTS + 2; i++)
            send_cmd(pods_pkg::ACT_REQ, 16'h0100 + 16'(i), 63'd5000 + 63'(i), '0);
        drain();  // sender pause with every result in
        for (int i = SLOTS + 1; i >= 0; i--)
            send_cmd(pods_pkg::ACT_RESP, 16'h0100 + 16'(i), '0, 63'd4000 + 63'(i * 3));
    endtask

    // realistic exchange: an occasional sync, then request and response with random small skews
    task automatic realistic_exchange(logic [15:0] seq);
        logic [62:0] base;
        base = {3'b0, $urandom} * 63'd1000;
        if ($urandom_range(0, 3) == 0)
            send_cmd(pods_pkg::ACT_SYNC, seq, base + 63'($urandom_range(0, 2000)),
                     base + 63'd1 + 63'($urandom_range(0, 2000)));
        send_cmd(pods_pkg::ACT_REQ, seq, base + 63'($urandom_range(0, 5000)), '0);
        send_cmd(pods_pkg::ACT_RESP, seq, rand_time(),
                 base + 63'($urandom_range(0, 5000)));
    endtask

    // a long run of samples into the averaging window
    task automatic test_window_fill();
        send_cmd(pods_pkg::ACT_SYNC, 16'h0, 63'd10_000, 63'd9_000);
        for (int i = 0; i < 250; i++) realistic_exchange(16'($urandom));
    endtask

    task automatic test_random();
        int items, r, k, slot;
        logic [15:0] seq;
        items = 0;
        while (items < 560) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                realistic_exchange(16'($urandom));
                items += 2;
            end else if (r < 70 && pending_count() > 0) begin
                // answer some outstanding request
                k = $urandom_range(0, SLOTS - 1);
                slot = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (slot < 0 && pend_vld[(k + i) % SLOTS]) slot = (k + i) % SLOTS;
                send_cmd(pods_pkg::ACT_RESP, pend_seq[slot], rand_time(), rand_time());
                items++;
            end else if (r < 80 && pending_count() < SLOTS - 2) begin
                send_cmd(pods_pkg::ACT_REQ, 16'($urandom), rand_time(), rand_time());
                items++;
            end else begin
                // noise: any action and any field values
                seq = 16'($urandom);
                send_cmd(2'($urandom), seq, rand_time(),
                         ($urandom_range(0, 9) == 0) ? 63'd0 : rand_time());
                items++;
            end
        end
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_no_master();
        test_sync();
        test_requests();
        test_table_full();
        test_window_fill();
        drain();
        test_random();
        drain();
        repeat (200) @(posedge i_clk);
        finished = 1'b1;
        $display("covered %0d results, %0d measurements, %0d table-full drops",
                 n_results, n_measured, n_full);
        $display("window held %0d samples at end, %0d mismatches", win_cnt, mismatches);
        if (mismatches == 0 && exp_wr == exp_rd) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
